/* design/fdip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdip_pkg: shared definitions for the decimal integer printer
// Character codes, power-of-ten table and controller/datapath bundles.
// ----------------------------------------------------------------------------
package fdip_pkg;

    localparam logic [7:0] C_CHR_PCT  = 8'h25;
    localparam logic [7:0] C_CHR_D    = 8'h64;
    localparam logic [7:0] C_CHR_I    = 8'h69;
    localparam logic [7:0] C_CHR_MIN  = 8'h2D;
    localparam logic [7:0] C_CHR_ZERO = 8'h30;
    localparam logic [7:0] C_CHR_NUL  = 8'h00;

    localparam int unsigned C_NUM_POW = 10;
    localparam int unsigned C_PIDX_W  = 4;
    localparam int unsigned C_THR_W   = 36;

    localparam logic [C_THR_W-1:0] C_POW10 [C_NUM_POW] = '{
        36'd1, 36'd10, 36'd100, 36'd1000, 36'd10000, 36'd100000,
        36'd1000000, 36'd10000000, 36'd100000000, 36'd1000000000
    };

    typedef struct packed {
        logic load;
        logic emit_pre;
        logic emit_body;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic dec_lone;
        logic dec_pre;
        logic dec_num;
        logic job_num;
        logic last_digit;
        logic slot_free;
    } t_sts;

endpackage

/* design/fdip_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdip_ctrl: sequencer for the decimal integer printer
// Steps one accepted item through prefix, body or digit beats.
// ----------------------------------------------------------------------------
module fdip_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fdip_pkg::t_sts i_sts,
    output fdip_pkg::t_cmd o_cmd
);
    import fdip_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PRE   = 2'd1;
    localparam logic [1:0] ST_BODY  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    priority if (i_sts.dec_lone) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.dec_pre) begin
                        n_state = ST_PRE;
                    end else if (i_sts.dec_num) begin
                        n_state = ST_DIGIT;
                    end else begin
                        n_state = ST_BODY;
                    end
                end
            end
            ST_PRE: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit_pre = 1'b1;
                    n_state = i_sts.job_num ? ST_DIGIT : ST_BODY;
                end
            end
            ST_BODY: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit_body = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DIGIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.last_digit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/fdip_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdip_datapath: decode, digit extraction, count and output register
// Produces one output beat per emit command from the sequencer.
// ----------------------------------------------------------------------------
module fdip_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fdip_pkg::t_cmd       i_cmd,
    output fdip_pkg::t_sts       o_sts,
    input  logic [7:0]           i_format_char,
    input  logic                 i_is_terminator,
    input  logic signed [31:0]   i_arg_value,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [7:0]           o_out_char,
    output logic                 o_char_valid,
    output logic                 o_last,
    output logic                 o_done_res,
    output logic [31:0]          o_total_count
);
    import fdip_pkg::*;

    // job registers
    logic                r_pending;
    logic                r_term;
    logic                r_num;
    logic [7:0]          r_pre_char;
    logic [7:0]          r_char;
    logic [31:0]         r_rem;
    logic [C_PIDX_W-1:0] r_pidx;
    logic [31:0]         r_count;

    // output register
    logic                r_valid;
    logic [7:0]          r_out_char;
    logic                r_char_valid;
    logic                r_last;
    logic                r_done;
    logic [31:0]         r_total;

    logic                w_is_pct;
    logic                w_is_dec;
    logic                w_neg;
    logic [31:0]         w_arg;
    logic [31:0]         w_mag;
    logic [C_PIDX_W-1:0] w_ndig_m1;
    logic [31:0]         w_cnt_inc;
    logic [C_THR_W-1:0]  w_thr [C_NUM_POW];
    logic [3:0]          w_digit;
    logic [C_THR_W-1:0]  w_sub;
    logic                w_slot_free;

    assign w_arg    = i_arg_value;
    assign w_is_pct = (i_format_char == C_CHR_PCT);
    assign w_is_dec = (i_format_char == C_CHR_D) || (i_format_char == C_CHR_I);
    assign w_neg    = w_arg[31];
    assign w_mag    = w_neg ? (32'd0 - w_arg) : w_arg;

    always_comb begin
        w_ndig_m1 = '0;
        for (int p = 1; p < C_NUM_POW; p++) begin
            if ({4'd0, w_mag} >= C_POW10[p]) begin
                w_ndig_m1 = w_ndig_m1 + 4'd1;
            end
        end
    end

    // thresholds k * 10^p for the current digit place
    always_comb begin
        w_digit  = 4'd0;
        w_thr[0] = '0;
        for (int k = 1; k < C_NUM_POW; k++) begin
            w_thr[k] = C_POW10[r_pidx] * C_THR_W'(k);
            if ({4'd0, r_rem} >= w_thr[k]) begin
                w_digit = 4'(k);
            end
        end
        w_sub = w_thr[w_digit];
    end

    assign w_cnt_inc   = (r_count == 32'hFFFF_FFFF) ? r_count : (r_count + 32'd1);
    assign w_slot_free = !r_valid || i_ready;

    assign o_sts.dec_lone   = !i_is_terminator && !r_pending && w_is_pct;
    assign o_sts.dec_num    = !i_is_terminator && r_pending && w_is_dec;
    assign o_sts.dec_pre    = !i_is_terminator && r_pending
                              && ((w_is_dec && w_neg) || (!w_is_dec && !w_is_pct));
    assign o_sts.job_num    = r_num;
    assign o_sts.last_digit = (r_pidx == '0);
    assign o_sts.slot_free  = w_slot_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_count   <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pending <= !i_is_terminator && !r_pending && w_is_pct;
            end
            priority if (i_cmd.emit_pre || i_cmd.emit_digit) begin
                r_count <= w_cnt_inc;
            end else if (i_cmd.emit_body) begin
                r_count <= r_term ? '0 : w_cnt_inc;
            end
            priority if (i_cmd.emit_pre || i_cmd.emit_body || i_cmd.emit_digit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_term     <= i_is_terminator;
            r_num      <= r_pending && w_is_dec;
            r_pre_char <= (r_pending && w_is_dec) ? C_CHR_MIN : C_CHR_PCT;
            r_char     <= (r_pending && w_is_pct) ? C_CHR_PCT : i_format_char;
            r_rem      <= w_mag;
            r_pidx     <= w_ndig_m1;
        end
        if (i_cmd.emit_digit) begin
            r_rem  <= r_rem - w_sub[31:0];
            r_pidx <= r_pidx - 4'd1;
        end
        priority if (i_cmd.emit_pre) begin
            r_out_char   <= r_pre_char;
            r_char_valid <= 1'b1;
            r_last       <= 1'b0;
            r_done       <= 1'b0;
            r_total      <= w_cnt_inc;
        end else if (i_cmd.emit_body) begin
            r_out_char   <= r_term ? C_CHR_NUL : r_char;
            r_char_valid <= !r_term;
            r_last       <= 1'b1;
            r_done       <= r_term;
            r_total      <= r_term ? r_count : w_cnt_inc;
        end else if (i_cmd.emit_digit) begin
            r_out_char   <= C_CHR_ZERO + {4'd0, w_digit};
            r_char_valid <= 1'b1;
            r_last       <= (r_pidx == '0);
            r_done       <= 1'b0;
            r_total      <= w_cnt_inc;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_char    = r_out_char;
    assign o_char_valid  = r_char_valid;
    assign o_last        = r_last;
    assign o_done_res    = r_done;
    assign o_total_count = r_total;

endmodule

/* design/format_decimal_integer_printer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_decimal_integer_printer: %d / %i style format string printer
// Takes one format byte plus a signed argument per input beat and emits
// the printed characters, one per output beat, with a running count.
//
// Input channel i_valid / o_ready carries format_char, is_terminator and
// arg_value. Output channel o_valid / i_ready carries out_char, char_valid,
// last, done_res and total_count. A terminator beat yields one done beat
// with the final count and starts a new string.
// An item is taken only when the sequencer is idle; its results then
// leave at one beat per cycle from the output register while the
// receiver keeps up. A number item yields an optional '-' and up to ten
// digits, one digit place per cycle through the power-of-ten compare
// unit; a plain byte yields one beat (two after a pending '%'), a lone
// '%' none. The next item may be accepted while the last beat of the
// previous one still waits in the output register. A stalled receiver
// holds the output register and pauses the sequencer. Reset clears the
// sequencer, the pending '%', the count and the output valid.
// ----------------------------------------------------------------------------
module format_decimal_integer_printer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_format_char,
    input  logic               i_is_terminator,
    input  logic signed [31:0] i_arg_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_char,
    output logic               o_char_valid,
    output logic               o_last,
    output logic               o_done_res,
    output logic [31:0]        o_total_count
);
    import fdip_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    fdip_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    fdip_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_format_char   (i_format_char),
        .i_is_terminator (i_is_terminator),
        .i_arg_value     (i_arg_value),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_out_char      (o_out_char),
        .o_char_valid    (o_char_valid),
        .o_last          (o_last),
        .o_done_res      (o_done_res),
        .o_total_count   (o_total_count)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.emit_pre, w_cmd.emit_body, w_cmd.emit_digit}))
        else $error("more than one command in a cycle");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_pre || w_cmd.emit_body || w_cmd.emit_digit) |-> w_sts.slot_free)
        else $error("beat issued into an occupied output register");

    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (o_last && !o_char_valid))
        else $error("done beat not marked last or carries a character");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_pre || w_cmd.emit_body || w_cmd.emit_digit) |=> o_valid)
        else $error("issued beat not presented");

endmodule

/* tb/fdip_print_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdip_print_checker: output checker for the decimal integer printer
// Watches both channels of the printer. Every accepted format beat is
// expanded into the characters it prints, with its own pending-percent
// flag and saturating character count. Every accepted output beat is
// compared field by field against the oldest predicted character. The
// mismatch total and the number of characters still due go to the top.
// ----------------------------------------------------------------------------
module fdip_print_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_format_char,
    input  logic               i_is_terminator,
    input  logic signed [31:0] i_arg_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [7:0]         i_out_char,
    input  logic               i_char_valid,
    input  logic               i_last,
    input  logic               i_done_res,
    input  logic [31:0]        i_total_count,
    output int                 o_fail_count,
    output int                 o_pending
);
    import fdip_pkg::*;

    typedef struct packed {
        logic [7:0]  chr;
        logic        chr_valid;
        logic        last;
        logic        done;
        logic [31:0] count;
    } t_printed_char;

    t_printed_char printed_chars_due[$];
    logic          pct_armed;
    logic [31:0]   chars_printed;
    int            mismatch_total = 0;

    function automatic void print_char(input logic [7:0] chr);
        t_printed_char beat;
        if (chars_printed != 32'hFFFF_FFFF) begin
            chars_printed = chars_printed + 32'd1;
        end
        beat.chr       = chr;
        beat.chr_valid = 1'b1;
        beat.last      = 1'b0;
        beat.done      = 1'b0;
        beat.count     = chars_printed;
        printed_chars_due.push_back(beat);
    endfunction

    function automatic void print_decimal(input logic [31:0] raw);
        logic [31:0] mag;
        logic [7:0]  digits [10];
        int          nd;
        nd = 0;
        if (raw[31]) begin
            print_char(C_CHR_MIN);
            mag = 32'd0 - raw;
        end else begin
            mag = raw;
        end
        do begin
            digits[nd] = C_CHR_ZERO + 8'(mag % 32'd10);
            mag = mag / 32'd10;
            nd++;
        end while (mag != 32'd0 && nd < 10);
        for (int k = nd - 1; k >= 0; k--) begin
            print_char(digits[k]);
        end
    endfunction

    function automatic void expand_format_beat(input logic [7:0] chr, input logic term,
                                               input logic [31:0] arg);
        t_printed_char beat;
        if (term) begin
            beat.chr       = C_CHR_NUL;
            beat.chr_valid = 1'b0;
            beat.last      = 1'b1;
            beat.done      = 1'b1;
            beat.count     = chars_printed;
            printed_chars_due.push_back(beat);
            pct_armed     = 1'b0;
            chars_printed = 32'd0;
            return;
        end
        if (pct_armed) begin
            pct_armed = 1'b0;
            if (chr == C_CHR_PCT) begin
                print_char(C_CHR_PCT);
            end else if (chr == C_CHR_D || chr == C_CHR_I) begin
                print_decimal(arg);
            end else begin
                print_char(C_CHR_PCT);
                print_char(chr);
            end
        end else if (chr == C_CHR_PCT) begin
            pct_armed = 1'b1;
            return;
        end else begin
            print_char(chr);
        end
        beat = printed_chars_due.pop_back();
        beat.last = 1'b1;
        printed_chars_due.push_back(beat);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_printed_char want;
        if (!i_rst_n) begin
            printed_chars_due.delete();
            pct_armed     = 1'b0;
            chars_printed = 32'd0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (printed_chars_due.size() == 0) begin
                    $display("%0t: unexpected beat, expected none actual char %0h done %0b",
                             $time, i_out_char, i_done_res);
                    mismatch_total++;
                end else begin
                    want = printed_chars_due.pop_front();
                    check_field("out_char", 32'(want.chr), 32'(i_out_char));
                    check_field("char_valid", 32'(want.chr_valid), 32'(i_char_valid));
                    check_field("last", 32'(want.last), 32'(i_last));
                    check_field("done_res", 32'(want.done), 32'(i_done_res));
                    check_field("total_count", want.count, i_total_count);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expand_format_beat(i_format_char, i_is_terminator, i_arg_value);
            end
        end
        o_pending    <= printed_chars_due.size();
        o_fail_count <= mismatch_total;
    end

endmodule

/* tb/tb_format_decimal_integer_printer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_format_decimal_integer_printer: testbench for the decimal integer printer
// Drives format beats through a directed set of corner cases (plain and zero
// bytes, percent escapes, extreme arguments, pending percent at the end) and
// then random format strings under three idling mixes, with a long receiver
// hold-off that backs up the input. A checker module predicts and compares
// every printed character; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_format_decimal_integer_printer;
    import fdip_pkg::*;

    localparam int CLK_PERIOD_NS    = 12;
    localparam int RST_CYCLES       = 12;
    localparam int RUN_LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 30;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_format_char;
    logic               i_is_terminator;
    logic signed [31:0] i_arg_value;
    logic               o_valid;
    logic               i_ready;
    logic [7:0]         o_out_char;
    logic               o_char_valid;
    logic               o_last;
    logic               o_done_res;
    logic [31:0]        o_total_count;

    int fail_count;
    int chars_due;
    int tx_idle_pct  = 37;
    int rx_idle_pct  = 71;
    int rx_hold_left = 0;
    int beats_sent   = 0;

    format_decimal_integer_printer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_format_char   (i_format_char),
        .i_is_terminator (i_is_terminator),
        .i_arg_value     (i_arg_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_char      (o_out_char),
        .o_char_valid    (o_char_valid),
        .o_last          (o_last),
        .o_done_res      (o_done_res),
        .o_total_count   (o_total_count)
    );

    fdip_print_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_format_char   (i_format_char),
        .i_is_terminator (i_is_terminator),
        .i_arg_value     (i_arg_value),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_out_char      (o_out_char),
        .i_char_valid    (o_char_valid),
        .i_last          (o_last),
        .i_done_res      (o_done_res),
        .i_total_count   (o_total_count),
        .o_fail_count    (fail_count),
        .o_pending       (chars_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD_NS);
        $display("format_decimal_integer_printer verification failed");
        $finish;
    end

    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                i_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_beat(input logic [7:0] chr, input logic term, input logic [31:0] arg);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_format_char   <= chr;
        i_is_terminator <= term;
        i_arg_value     <= arg;
        do @(posedge i_clk); while (!o_ready);
        beats_sent++;
    endtask

    task automatic wait_all_printed();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chars_due != 0);
    endtask

    function automatic logic [31:0] random_arg();
        logic [31:0] val;
        case ($urandom_range(3))
            0: val = $urandom;
            1: val = 32'($urandom_range(199)) - 32'd100;
            2: begin
                case ($urandom_range(3))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7FFF_FFFF;
                    2: val = 32'd0;
                    default: val = 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                val = $urandom >> $urandom_range(31);
                if ($urandom_range(1) == 1) val = 32'd0 - val;
            end
        endcase
        return val;
    endfunction

    task automatic send_random_string_piece();
        int          pick;
        logic [7:0]  chr;
        pick = $urandom_range(99);
        if (pick < 35) begin
            do chr = 8'($urandom); while (chr == C_CHR_PCT);
            send_beat(chr, 1'b0, $urandom);
        end else if (pick < 60) begin
            send_beat(C_CHR_PCT, 1'b0, $urandom);
            send_beat(($urandom_range(1) == 1) ? C_CHR_D : C_CHR_I, 1'b0, random_arg());
        end else if (pick < 68) begin
            send_beat(C_CHR_PCT, 1'b0, $urandom);
            send_beat(C_CHR_PCT, 1'b0, $urandom);
        end else if (pick < 78) begin
            send_beat(C_CHR_PCT, 1'b0, $urandom);
            send_beat(8'($urandom), 1'b0, random_arg());
        end else if (pick < 86) begin
            send_beat(C_CHR_PCT, 1'b0, $urandom);
            send_beat(8'($urandom), 1'b1, $urandom);
        end else if (pick < 93) begin
            send_beat(8'($urandom), 1'b1, $urandom);
        end else begin
            send_beat(8'($urandom), 1'($urandom), $urandom);
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_format_char   <= C_CHR_NUL;
        i_is_terminator <= 1'b0;
        i_arg_value     <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat("A", 1'b0, 32'h0);
        send_beat(C_CHR_NUL, 1'b0, 32'hFFFF_FFFF);
        send_beat(8'hFF, 1'b0, 32'h0);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat(C_CHR_D, 1'b0, 32'd0);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat(C_CHR_I, 1'b0, 32'h8000_0000);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat(C_CHR_D, 1'b0, 32'h7FFF_FFFF);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat(C_CHR_I, 1'b0, 32'hFFFF_FFFF);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat("x", 1'b0, 32'h1234_5678);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat(C_CHR_NUL, 1'b0, 32'd5);
        send_beat(C_CHR_D, 1'b1, 32'hFFFF_FFFF);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat(C_CHR_PCT, 1'b1, 32'h0);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat(" ", 1'b0, 32'h0);
        send_beat(C_CHR_NUL, 1'b1, 32'h0);
        send_beat(C_CHR_PCT, 1'b0, 32'h0);
        send_beat(C_CHR_D, 1'b0, 32'd7);
        while (beats_sent < 45) send_random_string_piece();
        wait_all_printed();

        tx_idle_pct = 71;
        rx_idle_pct = 37;
        while (beats_sent < 90) send_random_string_piece();
        wait_all_printed();

        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = HOLD_CYCLES;
        repeat (8) begin
            send_beat(C_CHR_PCT, 1'b0, $urandom);
            send_beat(C_CHR_D, 1'b0, 32'h8000_0000 | $urandom);
        end
        while (beats_sent < 130) send_random_string_piece();
        send_beat(C_CHR_NUL, 1'b1, $urandom);
        wait_all_printed();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && chars_due == 0) begin
            $display("format_decimal_integer_printer verification clean");
        end else begin
            $display("format_decimal_integer_printer verification failed");
        end
        $finish;
    end

endmodule
